// File: hdl/atan2_pkg.sv
// Shared types and constants for the two-argument arctangent pipeline.
// Holds the CORDIC angle table and the sideband struct passed along the stages.
// No dependencies.
package atan2_pkg;

  localparam int CORDIC_STEPS = 31;
  localparam int PRESHIFT     = 30;
  localparam int ZANG_WIDTH   = 32;

  typedef logic [ZANG_WIDTH-1:0] zang_t;

  localparam zang_t HALF_PI = 32'h4000_0000;
  localparam zang_t FULL_PI = 32'h8000_0000;

  localparam zang_t ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001
  };

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic swap;
    logic zero;
  } side_t;

endpackage

// File: hdl/atan2_cordic_stage.sv
// One registered vectoring CORDIC iteration of the arctangent pipeline.
// Depends on atan2_pkg for the angle table, the angle type and the sideband struct.
module atan2_cordic_stage #(
  parameter int VEC_WIDTH = 48,
  parameter int STAGE     = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic signed [VEC_WIDTH-1:0] in_vx,
  input  logic signed [VEC_WIDTH-1:0] in_vy,
  input  atan2_pkg::zang_t            in_z,
  input  atan2_pkg::side_t            in_side,
  output logic                        out_valid,
  output logic signed [VEC_WIDTH-1:0] out_vx,
  output logic signed [VEC_WIDTH-1:0] out_vy,
  output atan2_pkg::zang_t            out_z,
  output atan2_pkg::side_t            out_side
);

  logic signed [VEC_WIDTH-1:0] xs;
  logic signed [VEC_WIDTH-1:0] ys;
  logic signed [VEC_WIDTH-1:0] vx_next;
  logic signed [VEC_WIDTH-1:0] vy_next;
  atan2_pkg::zang_t            z_next;

  always_comb begin
    xs = in_vx >>> STAGE;
    ys = in_vy >>> STAGE;
    if (in_vy == '0) begin
      vx_next = in_vx;
      vy_next = in_vy;
      z_next  = in_z;
    end else if (!in_vy[VEC_WIDTH-1]) begin
      vx_next = in_vx + ys;
      vy_next = in_vy - xs;
      z_next  = in_z + atan2_pkg::ATAN_TAB[STAGE];
    end else begin
      vx_next = in_vx - ys;
      vy_next = in_vy + xs;
      z_next  = in_z - atan2_pkg::ATAN_TAB[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_vx   <= vx_next;
      out_vy   <= vy_next;
      out_z    <= z_next;
      out_side <= in_side;
    end
  end

endmodule

// File: hdl/two_argument_arctangent.sv
// Four-quadrant arctangent: input decode, 31 CORDIC stages, quadrant fold and rounding.
// Depends on atan2_pkg and atan2_cordic_stage.
// An accepted beat passes the input, CORDIC stage, fold and rounding registers to done.
// Throughput: one beat per clock; busy is always low, as every stage is a register.
// Depth is set by one iteration of the vectoring CORDIC per pipeline stage.
// Reset clears the valid bits of all stages; data registers are not reset.
module two_argument_arctangent #(
  parameter int COORD_WIDTH     = 16,
  parameter int ANGLE_FRAC_BITS = 15
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [COORD_WIDTH-1:0]  coord_x,
  input  logic signed [COORD_WIDTH-1:0]  coord_y,
  output logic                           done,
  output logic signed [ANGLE_FRAC_BITS+1:0] angle,
  output logic                           zero_vector
);

  localparam int CW        = COORD_WIDTH;
  localparam int VW        = COORD_WIDTH + 32;
  localparam int AW        = ANGLE_FRAC_BITS + 2;
  localparam int STEPS     = atan2_pkg::CORDIC_STEPS;
  localparam int RND_SHIFT = 31 - ANGLE_FRAC_BITS;
  localparam logic [32:0] RND_HALF = (33'd1 << RND_SHIFT) >> 1;
  localparam int LAT       = STEPS + 4;
  localparam logic signed [AW-1:0] ANG_PI = AW'(1) << ANGLE_FRAC_BITS;

  logic                xneg;
  logic                yneg;
  logic [CW-1:0]       ax;
  logic [CW-1:0]       ay;
  logic                swap;
  logic [CW-1:0]       num;
  logic [CW-1:0]       den;
  atan2_pkg::side_t    side_in;

  logic                    valid_pipe [STEPS+1];
  logic signed [VW-1:0]    vx_pipe    [STEPS+1];
  logic signed [VW-1:0]    vy_pipe    [STEPS+1];
  atan2_pkg::zang_t        z_pipe     [STEPS+1];
  atan2_pkg::side_t        side_pipe  [STEPS+1];

  logic                valid_fold;
  logic [32:0]         t_fold;
  atan2_pkg::side_t    side_fold;
  logic [32:0]         t_next;

  logic                valid_rnd;
  logic [AW-1:0]       mag_rnd;
  atan2_pkg::side_t    side_rnd;
  logic [32:0]         rnd_sum;

  assign busy = 1'b0;

  always_comb begin
    xneg = coord_x[CW-1];
    yneg = coord_y[CW-1];
    ax   = xneg ? (~$unsigned(coord_x) + {{(CW-1){1'b0}}, 1'b1}) : $unsigned(coord_x);
    ay   = yneg ? (~$unsigned(coord_y) + {{(CW-1){1'b0}}, 1'b1}) : $unsigned(coord_y);
    swap = (ay >= ax);
    num  = swap ? ax : ay;
    den  = swap ? ay : ax;
    side_in.xneg = xneg;
    side_in.yneg = yneg;
    side_in.swap = swap;
    side_in.zero = (ax == '0) && (ay == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe[0] <= 1'b0;
    end else begin
      valid_pipe[0] <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      vx_pipe[0]   <= $signed({2'b00, den, {atan2_pkg::PRESHIFT{1'b0}}});
      vy_pipe[0]   <= $signed({2'b00, num, {atan2_pkg::PRESHIFT{1'b0}}});
      z_pipe[0]    <= '0;
      side_pipe[0] <= side_in;
    end
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_stage
    atan2_cordic_stage #(
      .VEC_WIDTH (VW),
      .STAGE     (g)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_pipe[g]),
      .in_vx     (vx_pipe[g]),
      .in_vy     (vy_pipe[g]),
      .in_z      (z_pipe[g]),
      .in_side   (side_pipe[g]),
      .out_valid (valid_pipe[g+1]),
      .out_vx    (vx_pipe[g+1]),
      .out_vy    (vy_pipe[g+1]),
      .out_z     (z_pipe[g+1]),
      .out_side  (side_pipe[g+1])
    );
  end

  // Fold the first-quadrant angle into the half circle from 0 to pi in a single add or subtract.
  always_comb begin
    unique case ({side_pipe[STEPS].swap, side_pipe[STEPS].xneg})
      2'b00: t_next = {1'b0, z_pipe[STEPS]};
      2'b10: t_next = {1'b0, atan2_pkg::HALF_PI} - {1'b0, z_pipe[STEPS]};
      2'b01: t_next = {1'b0, atan2_pkg::FULL_PI} - {1'b0, z_pipe[STEPS]};
      2'b11: t_next = {1'b0, atan2_pkg::HALF_PI} + {1'b0, z_pipe[STEPS]};
      default: t_next = '0;
    endcase
  end

  assign rnd_sum = t_fold + RND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_fold <= 1'b0;
      valid_rnd  <= 1'b0;
      done       <= 1'b0;
    end else begin
      valid_fold <= valid_pipe[STEPS];
      valid_rnd  <= valid_fold;
      done       <= valid_rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_pipe[STEPS]) begin
      t_fold    <= t_next;
      side_fold <= side_pipe[STEPS];
    end
    if (valid_fold) begin
      mag_rnd  <= rnd_sum[32:RND_SHIFT];
      side_rnd <= side_fold;
    end
    if (valid_rnd) begin
      zero_vector <= side_rnd.zero;
      if (side_rnd.zero) begin
        angle <= '0;
      end else if (side_rnd.yneg) begin
        angle <= $signed(AW'(0) - mag_rnd);
      end else begin
        angle <= $signed(mag_rnd);
      end
    end
  end

  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result beat without an accepted input beat");

  a_zero_angle: assert property (@(posedge clk) disable iff (rst)
    done && zero_vector |-> angle == '0)
    else $error("zero vector flagged with nonzero angle");

  a_zero_source: assert property (@(posedge clk) disable iff (rst)
    done |-> zero_vector == ($past(coord_x, LAT) == '0 && $past(coord_y, LAT) == '0))
    else $error("zero vector flag does not match the input beat");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    done && !zero_vector |-> (angle <= ANG_PI) && (angle >= -ANG_PI))
    else $error("angle outside of plus or minus pi");

  a_angle_sign: assert property (@(posedge clk) disable iff (rst)
    done && !zero_vector |->
      ($past(coord_y[CW-1], LAT) ? (angle <= 0) : (angle >= 0)))
    else $error("angle sign does not follow the vertical component");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the two_argument_arctangent pipeline.
// It drives directed and random coordinate pairs and checks every angle
// beat against a bit-exact CORDIC predictor. It depends on the block only.
module tb;

  localparam int CW  = 16;
  localparam int AFB = 15;
  localparam int RND_SHIFT = 31 - AFB;
  localparam int RANDOM_PAIRS = 650;

  localparam logic [63:0] Z_HALF_PI = 64'h4000_0000;
  localparam logic [63:0] Z_PI      = 64'h8000_0000;

  localparam logic [0:30][31:0] ANGLE_STEP = {
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001
  };

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } coord_pair_t;

  typedef struct {
    logic signed [AFB+1:0] angle;
    logic                  zero_vector;
  } angle_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [CW-1:0] coord_x = '0;
  logic signed [CW-1:0] coord_y = '0;
  logic busy;
  logic done;
  logic signed [AFB+1:0] angle;
  logic zero_vector;

  coord_pair_t pending_pairs[$];
  angle_beat_t expected_angles[$];
  int errors = 0;
  int checked = 0;
  int zero_seen = 0;
  int directed_count = 0;
  int gap_left = 0;

  two_argument_arctangent #(
    .COORD_WIDTH(CW),
    .ANGLE_FRAC_BITS(AFB)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .done(done),
    .angle(angle),
    .zero_vector(zero_vector)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Vectoring CORDIC on (d, n) scaled by 2^30; angle in units of pi/2^31.
  function automatic logic [63:0] ratio_atan(input logic [63:0] n, input logic [63:0] d);
    logic signed [63:0] vx, vy, xs, ys;
    logic [63:0] z;
    int i;
    vx = d << 30;
    vy = n << 30;
    z = '0;
    for (i = 0; i < 31; i++) begin
      if (vy == 0) break;
      xs = vx >>> i;
      ys = vy >>> i;
      if (!vy[63]) begin
        vx = vx + ys;
        vy = vy - xs;
        z = z + 64'(ANGLE_STEP[i]);
      end else begin
        vx = vx - ys;
        vy = vy + xs;
        z = z - 64'(ANGLE_STEP[i]);
      end
    end
    return z;
  endfunction

  function automatic angle_beat_t atan2_predict(input coord_pair_t p);
    angle_beat_t r;
    longint sx, sy;
    logic [63:0] ax, ay, t, m;
    sx = p.x;
    sy = p.y;
    ax = (sx < 0) ? 64'(-sx) : 64'(sx);
    ay = (sy < 0) ? 64'(-sy) : 64'(sy);
    if (ax == 0 && ay == 0) begin
      r.angle = '0;
      r.zero_vector = 1'b1;
      return r;
    end
    if (ax > ay) t = ratio_atan(ay, ax);
    else t = Z_HALF_PI - ratio_atan(ax, ay);
    if (sx < 0) t = Z_PI - t;
    m = (t + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
    if (sy < 0) m = 64'd0 - m;
    r.angle = m[AFB+1:0];
    r.zero_vector = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin : driver
    int r;
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        expected_angles.push_back(atan2_predict('{x: coord_x, y: coord_y}));
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        coord_x <= pending_pairs[0].x;
        coord_y <= pending_pairs[0].y;
        void'(pending_pairs.pop_front());
        start <= 1'b1;
        r = $urandom_range(0, 99);
        if (r < 60) gap_left <= 0;
        else if (r < 95) gap_left <= $urandom_range(1, 3);
        else gap_left <= $urandom_range(10, 40);
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    angle_beat_t want;
    if (!rst && done) begin
      if (expected_angles.size() == 0) begin
        $error("unexpected result beat: angle %0d, zero_vector %0b", angle, zero_vector);
        errors++;
      end else begin
        want = expected_angles.pop_front();
        checked++;
        if (want.zero_vector) zero_seen++;
        if (angle !== want.angle) begin
          $error("angle: expected %0d, got %0d", want.angle, angle);
          errors++;
        end
        if (zero_vector !== want.zero_vector) begin
          $error("zero_vector: expected %0b, got %0b", want.zero_vector, zero_vector);
          errors++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    coord_pair_t p;
    int k, m, kind;
    coord_pair_t directed[$];
    directed = '{
      '{x: 0, y: 0}, '{x: -32768, y: 0}, '{x: -1, y: 0}, '{x: 32767, y: 0},
      '{x: 1, y: 0}, '{x: 0, y: 32767}, '{x: 0, y: -32768}, '{x: 0, y: 1},
      '{x: 0, y: -1}, '{x: 100, y: 100}, '{x: -100, y: 100}, '{x: -100, y: -100},
      '{x: 100, y: -100}, '{x: -32768, y: -32768}, '{x: 32767, y: 32767},
      '{x: -32768, y: 32767}, '{x: 32767, y: -32768}, '{x: 1, y: 32767},
      '{x: 32767, y: 1}, '{x: -32768, y: 1}, '{x: -32768, y: -1},
      '{x: 1, y: -1}, '{x: -1, y: -1}, '{x: 0, y: 0}
    };
    foreach (directed[i]) pending_pairs.push_back(directed[i]);
    directed_count = directed.size();
    for (k = 0; k < RANDOM_PAIRS; k++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin
          p.x = CW'($urandom);
          p.y = CW'($urandom);
        end
        4: begin
          p.x = CW'($urandom_range(0, 15) - 8);
          p.y = CW'($urandom_range(0, 15) - 8);
        end
        5, 6: begin
          m = $urandom_range(1, 32768);
          p.x = CW'($urandom_range(0, 1) ? -m : m);
          p.y = CW'($urandom_range(0, 1) ? -m : m);
        end
        7: begin
          m = $urandom_range(1, 32767);
          p.x = CW'($urandom_range(0, 1) ? -m : m);
          m = m + ($urandom_range(0, 1) ? 1 : -1);
          p.y = CW'($urandom_range(0, 1) ? -m : m);
        end
        8: begin
          p.x = CW'($urandom);
          p.y = '0;
          if ($urandom_range(0, 1)) begin
            p.y = p.x;
            p.x = '0;
          end
        end
        default: begin
          p.x = CW'($urandom_range(0, 1) ? -32768 : 32767);
          p.y = CW'($urandom);
        end
      endcase
      pending_pairs.push_back(p);
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (pending_pairs.size() == 0 && !start);
    wait (expected_angles.size() == 0);
    repeat (40) @(posedge clk);
    $display("Checked %0d angle beats (%0d directed pairs, %0d random), %0d zero vectors.",
             checked, directed_count, RANDOM_PAIRS, zero_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/atan2_pkg.sv
hdl/atan2_cordic_stage.sv
hdl/two_argument_arctangent.sv
dv/tb.sv
